// ===== rtl/json_string_unescaper_defines.svh =====
// Assertion macros for the checker file of the JSON string unescaper.
// No dependencies.
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// Concurrent property, clocked on rising edge, off while reset is asserted.
`define JSU_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define JSU_ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/jsu_pkg.sv =====
// Types, character codes and helpers for the JSON string unescaper.
// No dependencies; used by the decoder, result register, top level and checker.
package jsu_pkg;

	localparam int unsigned BurstLen  = 4;
	localparam int unsigned BurstCntW = 3;
	localparam int unsigned HexDepth  = 3;
	localparam int unsigned AccumW    = 16;

	localparam logic [7:0] CHAR_QUOTE  = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_U      = 8'h75;
	localparam logic [7:0] CHAR_N      = 8'h6E;
	localparam logic [7:0] CHAR_T      = 8'h74;
	localparam logic [7:0] CHAR_R      = 8'h72;
	localparam logic [7:0] CHAR_B      = 8'h62;
	localparam logic [7:0] CHAR_F      = 8'h66;
	localparam logic [7:0] CODE_LF     = 8'h0A;
	localparam logic [7:0] CODE_TAB    = 8'h09;
	localparam logic [7:0] CODE_CR     = 8'h0D;
	localparam logic [7:0] CODE_BS     = 8'h08;
	localparam logic [7:0] CODE_FF     = 8'h0C;

	localparam logic [AccumW-1:0] UTF8_LIMIT1 = 16'h0080;
	localparam logic [AccumW-1:0] UTF8_LIMIT2 = 16'h0800;
	localparam logic [7:0]        UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0]        UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0]        UTF8_CONT   = 8'h80;
	localparam logic [5:0]        UTF8_MASK   = 6'h3F;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_BODY,
		MODE_ESC,
		MODE_HEX
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       start_of_string;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_done;
		logic       last_of_run;
	} result_t;

	// results of one input item; count == 0 means no result at all
	typedef struct packed {
		logic [BurstLen-1:0][7:0] bytes;
		logic [BurstCntW-1:0]     count;
		logic                     has_bytes;
		logic                     fin;
	} burst_t;

	// {is_hex, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== rtl/jsu_decode.sv =====
// Decoder: string state, \u collection and per-item result burst.
// Depends on jsu_pkg.
module jsu_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  jsu_pkg::item_t  item,
	output jsu_pkg::burst_t burst
);

	jsu_pkg::mode_t                  mode_q, mode_d;
	logic [1:0]                      hex_count_q, hex_count_d;
	logic [jsu_pkg::AccumW-1:0]      hex_accum_q, hex_accum_d;
	logic                            hex_stopped_q, hex_stopped_d;
	logic [7:0]                      hex_chars_q [jsu_pkg::HexDepth];
	logic                            chars_we;

	logic [7:0]                 b;
	logic [4:0]                 dig;
	logic [jsu_pkg::AccumW-1:0] take_accum;
	logic                       take_stopped;
	logic [7:0]                 esc_byte;
	logic [jsu_pkg::BurstCntW-1:0] nb;

	assign b   = item.in_byte;
	assign dig = jsu_pkg::hex_digit(b);

	always_comb begin
		take_accum   = hex_accum_q;
		take_stopped = hex_stopped_q;
		if (!hex_stopped_q) begin
			if (dig[4]) begin
				take_accum = {hex_accum_q[jsu_pkg::AccumW-5:0], dig[3:0]};
			end else begin
				take_stopped = 1'b1;
			end
		end
	end

	always_comb begin
		case (b)
			jsu_pkg::CHAR_N: esc_byte = jsu_pkg::CODE_LF;
			jsu_pkg::CHAR_T: esc_byte = jsu_pkg::CODE_TAB;
			jsu_pkg::CHAR_R: esc_byte = jsu_pkg::CODE_CR;
			jsu_pkg::CHAR_B: esc_byte = jsu_pkg::CODE_BS;
			jsu_pkg::CHAR_F: esc_byte = jsu_pkg::CODE_FF;
			default:         esc_byte = b;
		endcase
	end

	// outputs: result burst and string end
	always_comb begin
		burst = '0;
		nb    = '0;
		if (item.start_of_string) begin
			burst.fin = (b != jsu_pkg::CHAR_QUOTE) | item.end_of_text;
		end else begin
			case (mode_q)
				jsu_pkg::MODE_BODY: begin
					if (b == jsu_pkg::CHAR_QUOTE) begin
						burst.fin = 1'b1;
					end else if (b != jsu_pkg::CHAR_BSLASH) begin
						burst.bytes[0] = b;
						nb = 3'd1;
					end
					if (item.end_of_text) begin
						burst.fin = 1'b1;
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (b != jsu_pkg::CHAR_U) begin
						burst.bytes[0] = esc_byte;
						nb = 3'd1;
					end
					burst.fin = item.end_of_text;
				end
				jsu_pkg::MODE_HEX: begin
					if (hex_count_q != 2'd3) begin
						if (item.end_of_text) begin
							burst.bytes[0] = (hex_count_q == 2'd0) ? b : hex_chars_q[0];
							burst.bytes[1] = (hex_count_q == 2'd1) ? b : hex_chars_q[1];
							burst.bytes[2] = b;
							nb = {1'b0, hex_count_q} + 3'd1;
							burst.fin = 1'b1;
						end
					end else begin
						if (take_accum < jsu_pkg::UTF8_LIMIT1) begin
							burst.bytes[0] = take_accum[7:0];
							nb = 3'd1;
						end else if (take_accum < jsu_pkg::UTF8_LIMIT2) begin
							burst.bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, take_accum[10:6]};
							burst.bytes[1] = jsu_pkg::UTF8_CONT
								| {2'b00, take_accum[5:0] & jsu_pkg::UTF8_MASK};
							nb = 3'd2;
						end else begin
							burst.bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'h0, take_accum[15:12]};
							burst.bytes[1] = jsu_pkg::UTF8_CONT
								| {2'b00, take_accum[11:6] & jsu_pkg::UTF8_MASK};
							burst.bytes[2] = jsu_pkg::UTF8_CONT
								| {2'b00, take_accum[5:0] & jsu_pkg::UTF8_MASK};
							nb = 3'd3;
						end
						burst.fin = item.end_of_text;
					end
				end
				default: begin
				end
			endcase
		end
		burst.has_bytes = (nb != 3'd0);
		burst.count     = (nb != 3'd0) ? nb : {2'b00, burst.fin};
	end

	// next state
	always_comb begin
		mode_d        = mode_q;
		hex_count_d   = hex_count_q;
		hex_accum_d   = hex_accum_q;
		hex_stopped_d = hex_stopped_q;
		chars_we      = 1'b0;
		if (item.start_of_string) begin
			mode_d        = jsu_pkg::MODE_BODY;
			hex_count_d   = '0;
			hex_accum_d   = '0;
			hex_stopped_d = 1'b0;
		end else begin
			case (mode_q)
				jsu_pkg::MODE_BODY: begin
					if (b == jsu_pkg::CHAR_BSLASH) begin
						mode_d = jsu_pkg::MODE_ESC;
					end
				end
				jsu_pkg::MODE_ESC: begin
					if (b == jsu_pkg::CHAR_U) begin
						mode_d        = jsu_pkg::MODE_HEX;
						hex_count_d   = '0;
						hex_accum_d   = '0;
						hex_stopped_d = 1'b0;
					end else begin
						mode_d = jsu_pkg::MODE_BODY;
					end
				end
				jsu_pkg::MODE_HEX: begin
					if (hex_count_q != 2'd3) begin
						if (!item.end_of_text) begin
							chars_we      = 1'b1;
							hex_accum_d   = take_accum;
							hex_stopped_d = take_stopped;
							hex_count_d   = hex_count_q + 2'd1;
						end
					end else begin
						mode_d        = jsu_pkg::MODE_BODY;
						hex_count_d   = '0;
						hex_accum_d   = '0;
						hex_stopped_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		if (burst.fin) begin
			mode_d        = jsu_pkg::MODE_IDLE;
			hex_count_d   = '0;
			hex_accum_d   = '0;
			hex_stopped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= jsu_pkg::MODE_IDLE;
			hex_count_q   <= '0;
			hex_accum_q   <= '0;
			hex_stopped_q <= 1'b0;
		end else if (advance) begin
			mode_q        <= mode_d;
			hex_count_q   <= hex_count_d;
			hex_accum_q   <= hex_accum_d;
			hex_stopped_q <= hex_stopped_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && chars_we) begin
			hex_chars_q[hex_count_q] <= b;
		end
	end

endmodule

// ===== rtl/jsu_emit.sv =====
// Result register: holds one burst and hands out its results one beat at a time.
// Depends on jsu_pkg.
module jsu_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::burst_t  burst_in,
	output logic             free,
	output logic             result_valid,
	input  logic             result_stall,
	output jsu_pkg::result_t result
);

	logic            busy_q;
	jsu_pkg::burst_t burst_q;
	logic [1:0]      idx_q;
	logic            last;
	logic            take;

	assign last = ({1'b0, idx_q} == (burst_q.count - 3'd1));
	assign take = busy_q & ~result_stall;
	assign free = ~busy_q | (take & last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst_in;
		end
	end

	assign result_valid       = busy_q;
	assign result.out_byte    = burst_q.has_bytes ? burst_q.bytes[idx_q] : 8'h00;
	assign result.byte_valid  = burst_q.has_bytes;
	assign result.last_of_run = last;
	assign result.string_done = last & burst_q.fin;

endmodule

// ===== rtl/json_string_unescaper.sv =====
// JSON string unescaper top level: input register, decoder, result register.
// An accepted item is registered, decoded, and its burst loaded into the result register.
// Throughput: one item and one result beat per cycle while the result port is not stalled;
// an item giving more than one result beat stalls the input until its last beat is taken.
// Reset (arst_n low, asynchronous): idle, waiting for a start byte; no results pending.
module json_string_unescaper (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  jsu_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output jsu_pkg::result_t result
);

	jsu_pkg::item_t  item_s1;
	logic            valid_s1;
	logic            emit_free;
	logic            advance;
	jsu_pkg::burst_t burst;

	assign advance    = valid_s1 & emit_free;
	assign item_stall = valid_s1 & ~emit_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	jsu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.burst   (burst)
	);

	jsu_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && (burst.count != '0)),
		.burst_in     (burst),
		.free         (emit_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== rtl/jsu_checker.sv =====
// Port-level checks for json_string_unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper_defines.svh.
`include "json_string_unescaper_defines.svh"

module jsu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input jsu_pkg::result_t result
);

	`JSU_ASSERT(a_result_hold, clk, arst_n, result_valid && result_stall |=> result_valid && $stable(result), "stalled result beat changed")
	`JSU_ASSERT_IMPLY(a_empty_is_done, clk, arst_n, result_valid && !result.byte_valid, result.string_done && result.last_of_run && result.out_byte == 8'h00, "empty beat must be a lone done beat")
	`JSU_ASSERT_IMPLY(a_done_is_last, clk, arst_n, result_valid && result.string_done, result.last_of_run, "string done before end of run")
	`JSU_ASSERT(a_run_continues, clk, arst_n, result_valid && !result_stall && !result.last_of_run |=> result_valid && result.byte_valid, "run broken before its last beat")
	`JSU_ASSERT_IMPLY(a_stall_needs_beat, clk, arst_n, item_stall, result_valid && (result_stall || !result.last_of_run), "input stalled with result port free")

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
